FILE: rtl/gqi_pkg.sv
// Shared types, constants and small tables for the gyro quaternion integrator.
// No dependencies; every other file in rtl/ imports this package.
package gqi_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_TIME_STEP      = 2'd0,
		CFG_RATE_THRESHOLD = 2'd1
	} gqi_cfg_idx_t;

	localparam logic [15:0]        TIME_STEP_RST  = 16'd10486;
	localparam logic [14:0]        RATE_THR_RST   = 15'd0;
	localparam logic signed [31:0] ATT_ONE        = 32'sh4000_0000;
	localparam logic signed [32:0] CORDIC_GAIN    = 33'sd652032874;
	localparam logic [4:0]         CORDIC_LAST    = 5'd29;
	localparam logic [63:0]        CONE_HALF      = 64'h0000_000C_0000_0000;
	localparam logic [31:0]        RECIP3         = 32'hAAAA_AAAB;

	// Sample and result payloads
	typedef struct packed {
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
	} gqi_in_t;

	typedef struct packed {
		logic signed [15:0] att_w;
		logic signed [15:0] att_x;
		logic signed [15:0] att_y;
		logic signed [15:0] att_z;
	} gqi_out_t;

	typedef logic signed [16:0] gqi_sum_t;
	typedef logic signed [32:0] gqi_cross_t;

	// Classified sample handed from front to back
	typedef struct packed {
		gqi_sum_t   [2:0] s;
		gqi_cross_t [2:0] c;
		logic       [33:0] n2;
		logic              upd;
	} gqi_job_t;

	// floor(atan(2^-i) * 2^30), but entries 27 to 29 are one above the floor
	function automatic logic [29:0] atan_entry(input logic [4:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd843314856;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043836;
			5'd3:  v = 30'd133525158;
			5'd4:  v = 30'd67021686;
			5'd5:  v = 30'd33543515;
			5'd6:  v = 30'd16775850;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194282;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048575;
			5'd11: v = 30'd524287;
			5'd12: v = 30'd262143;
			5'd13: v = 30'd131071;
			5'd14: v = 30'd65535;
			5'd15: v = 30'd32767;
			5'd16: v = 30'd16383;
			5'd17: v = 30'd8191;
			5'd18: v = 30'd4095;
			5'd19: v = 30'd2047;
			5'd20: v = 30'd1023;
			5'd21: v = 30'd511;
			5'd22: v = 30'd255;
			5'd23: v = 30'd127;
			5'd24: v = 30'd63;
			5'd25: v = 30'd31;
			5'd26: v = 30'd15;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	// Hamilton product: output j, term k uses a[k]*b[j^k]; true where subtracted
	function automatic logic term_neg(input logic [1:0] j, input logic [1:0] k);
		logic [3:0] jk;
		jk = {j, k};
		return (jk == 4'b0001) || (jk == 4'b0010) || (jk == 4'b0011) ||
			(jk == 4'b0111) || (jk == 4'b1001) || (jk == 4'b1110);
	endfunction

endpackage

FILE: rtl/gqi_front.sv
// Front end: accepts gyro samples, forms the sum of new and previous rate, cross product and
// threshold decision. Depends on gqi_pkg.
module gqi_front import gqi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  gqi_in_t     in_data,
	input  logic [14:0] rate_threshold,
	input  logic        q_full,
	output logic        q_push,
	output gqi_job_t    q_entry
);

	logic signed [15:0] nr [3];
	logic signed [15:0] prev_q [3];
	logic               v_s1, v_s2;
	logic               adv_s1, adv_s2, acc;
	gqi_sum_t           s_s1 [3];
	gqi_sum_t           s_s2 [3];
	logic signed [31:0] p_s1 [6];
	logic [32:0]        sq_s2 [3];
	gqi_cross_t         c_s2 [3];
	logic [33:0]        n2;
	logic [31:0]        thr4;

	assign nr[0] = in_data.rate_x;
	assign nr[1] = in_data.rate_y;
	assign nr[2] = in_data.rate_z;

	// stage handshakes
	assign adv_s2   = v_s2 && !q_full;
	assign adv_s1   = v_s1 && (!v_s2 || adv_s2);
	assign in_ready = !v_s1 || adv_s1;
	assign acc      = in_valid && in_ready;

	// control and previous sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i < 3; i++) prev_q[i] <= 16'sd0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
				for (int i = 0; i < 3; i++) prev_q[i] <= nr[i];
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1)
				v_s2 <= 1'b1;
			else if (adv_s2)
				v_s2 <= 1'b0;
		end
	end

	// stage 1: sums and cross product partials; stage 2: squares and differences
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < 3; i++) s_s1[i] <= 17'(nr[i]) + 17'(prev_q[i]);
			p_s1[0] <= prev_q[1] * nr[2];
			p_s1[1] <= prev_q[2] * nr[1];
			p_s1[2] <= prev_q[2] * nr[0];
			p_s1[3] <= prev_q[0] * nr[2];
			p_s1[4] <= prev_q[0] * nr[1];
			p_s1[5] <= prev_q[1] * nr[0];
		end
		if (adv_s1) begin
			for (int i = 0; i < 3; i++) begin
				s_s2[i]  <= s_s1[i];
				sq_s2[i] <= 33'(s_s1[i] * s_s1[i]);
			end
			c_s2[0] <= 33'(p_s1[0]) - 33'(p_s1[1]);
			c_s2[1] <= 33'(p_s1[2]) - 33'(p_s1[3]);
			c_s2[2] <= 33'(p_s1[4]) - 33'(p_s1[5]);
		end
	end

	// magnitude check against 4*thr^2
	always_comb begin
		n2   = 34'(sq_s2[0]) + 34'(sq_s2[1]) + 34'(sq_s2[2]);
		thr4 = {30'(rate_threshold) * 30'(rate_threshold), 2'b00};
		for (int i = 0; i < 3; i++) begin
			q_entry.s[i] = s_s2[i];
			q_entry.c[i] = c_s2[i];
		end
		q_entry.n2  = n2;
		q_entry.upd = n2 > 34'(thr4);
	end

	assign q_push = adv_s2;

endmodule

FILE: rtl/gqi_queue.sv
// Two-entry queue between front and back end.
// Depends on gqi_pkg for the entry type.
module gqi_queue import gqi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  gqi_job_t wr_data,
	input  logic     pop,
	output gqi_job_t rd_data,
	output logic     full,
	output logic     empty
);

	gqi_job_t   mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wr_data;
	end

endmodule

FILE: rtl/gqi_back.sv
// Back end: sequencer with shared bit-serial square root and divider, CORDIC,
// coning term, normalization and quaternion product. Depends on gqi_pkg.
module gqi_back import gqi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  gqi_job_t    q_head,
	output logic        q_pop,
	input  logic [15:0] time_step,
	output logic        out_valid,
	input  logic        out_ready,
	output gqi_out_t    out_data
);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_SQRT_M = 15'b000000000000010,
		ST_PHI    = 15'b000000000000100,
		ST_CORDIC = 15'b000000000001000,
		ST_CONE_A = 15'b000000000010000,
		ST_CONE_B = 15'b000000000100000,
		ST_CONE_C = 15'b000000001000000,
		ST_VMUL   = 15'b000000010000000,
		ST_VDIV   = 15'b000000100000000,
		ST_NSQ    = 15'b000001000000000,
		ST_SQRT_R = 15'b000010000000000,
		ST_NDIV   = 15'b000100000000000,
		ST_QMUL   = 15'b001000000000000,
		ST_COMMIT = 15'b010000000000000,
		ST_OUT    = 15'b100000000000000
	} gqi_state_t;

	gqi_state_t         state_q;
	logic [5:0]         cnt_q;
	logic [1:0]         idx_q;
	gqi_job_t           job_q;
	logic signed [31:0] att_q [4];
	logic signed [31:0] attn_q [4];
	logic               out_valid_q;
	gqi_out_t           out_q;

	logic [24:0]        m_q;
	logic [31:0]        r_q;
	logic signed [32:0] cx_q, cy_q, cz_q;
	logic signed [32:0] cone_q [3];
	logic signed [32:0] b_q [4];
	logic [47:0]        cm_q;
	logic [63:0]        ct_q;
	logic signed [49:0] vp_q;
	logic [63:0]        nn_q;
	logic signed [64:0] qp_q;
	logic               qneg_q;
	logic signed [65:0] acc_q;

	// square root unit
	logic [63:0] sq_src_q;
	logic [33:0] sq_rem_q;
	logic [31:0] sq_root_q;
	logic [35:0] sq_rem2, sq_trial;
	logic        sq_ge;
	logic [31:0] sq_root_nx;
	logic [63:0] sq_load;

	// divider unit
	logic [31:0] dv_rem_q, dv_lo_q, dv_quo_q, dv_den_q;
	logic        dv_neg_q;
	logic [32:0] dv_rem2;
	logic        dv_ge;
	logic [31:0] dv_quo_nx;
	logic signed [32:0] dv_qs;
	logic [63:0] dv_num, dv_n;
	logic [31:0] dv_den;
	logic        dv_neg;
	logic [49:0] vmag;
	logic [32:0] bmag;

	// other per-state logic
	logic [41:0]        phi_full;
	logic signed [32:0] dxs, dys, atan_s;
	logic [32:0]        cmag;
	logic [28:0]        cone_t;
	logic [60:0]        cone_p;
	logic [27:0]        cone_q3;
	logic [31:0]        nsq_mag;
	logic [3:0]         qu;
	logic signed [65:0] qterm, acc_nx, fsum;
	logic signed [37:0] fsh;
	logic signed [31:0] fin;
	logic               busy_ld, sqrt_st, div_st;

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign busy_ld   = !out_valid_q || out_ready;
	assign sqrt_st   = (state_q == ST_SQRT_M) || (state_q == ST_SQRT_R);
	assign div_st    = (state_q == ST_VDIV) || (state_q == ST_NDIV);

	// square root step and operand select
	always_comb begin
		sq_load    = (state_q == ST_SQRT_M) ? {14'd0, job_q.n2, 16'd0} : nn_q;
		sq_rem2    = {sq_rem_q, sq_src_q[63:62]};
		sq_trial   = {2'b00, sq_root_q, 2'b01};
		sq_ge      = sq_rem2 >= sq_trial;
		sq_root_nx = {sq_root_q[30:0], sq_ge};
	end

	// divider step and operand select (rounded magnitude division)
	always_comb begin
		vmag = vp_q[49] ? 50'(-vp_q) : 50'(vp_q);
		bmag = b_q[idx_q][32] ? 33'(-b_q[idx_q]) : 33'(b_q[idx_q]);
		if (state_q == ST_VDIV) begin
			dv_num = {6'd0, vmag, 8'd0};
			dv_den = {7'd0, m_q};
			dv_neg = vp_q[49];
		end else begin
			dv_num = {1'b0, bmag, 30'd0};
			dv_den = r_q;
			dv_neg = b_q[idx_q][32];
		end
		dv_n      = dv_num + {33'd0, dv_den[31:1]};
		dv_rem2   = {dv_rem_q, dv_lo_q[31]};
		dv_ge     = dv_rem2 >= {1'b0, dv_den_q};
		dv_quo_nx = {dv_quo_q[30:0], dv_ge};
		dv_qs     = dv_neg_q ? -$signed({1'b0, dv_quo_nx}) : $signed({1'b0, dv_quo_nx});
	end

	// CORDIC, coning, norm and product datapath terms
	always_comb begin
		phi_full = 42'(m_q) * 42'(time_step) + 42'd1024;
		dxs      = cy_q >>> cnt_q[4:0];
		dys      = cx_q >>> cnt_q[4:0];
		atan_s   = $signed({3'b000, atan_entry(cnt_q[4:0])});
		cmag     = job_q.c[idx_q][32] ? 33'(-$signed(job_q.c[idx_q])) : 33'(job_q.c[idx_q]);
		cone_t   = ct_q[63:35];
		cone_p   = 61'(cone_t) * 61'(RECIP3);
		cone_q3  = cone_p[60:33];
		nsq_mag  = b_q[cnt_q[1:0]][32] ? 32'(-b_q[cnt_q[1:0]]) : 32'(b_q[cnt_q[1:0]]);
		qu       = 4'(cnt_q - 6'd1);
		qterm    = 66'(qp_q >>> 2);
		if (qneg_q) qterm = -qterm;
		acc_nx   = (qu[1:0] == 2'd0) ? qterm : acc_q + qterm;
		fsum     = acc_nx + 66'sd134217728;
		fsh      = 38'(fsum >>> 28);
		if (fsh > 38'sd2147483647)
			fin = 32'sh7FFF_FFFF;
		else if (fsh < -38'sd2147483648)
			fin = 32'sh8000_0000;
		else
			fin = fsh[31:0];
	end

	function automatic logic signed [15:0] to_q14(input logic signed [31:0] a);
		logic signed [32:0] rs;
		logic signed [16:0] rv;
		rs = 33'(a) + 33'sd32768;
		rv = 17'(rs >>> 16);
		if (rv > 17'sd16384)
			return 16'sd16384;
		else if (rv < -17'sd16384)
			return -16'sd16384;
		return rv[15:0];
	endfunction

	// sequencer, attitude and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 6'd0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
			att_q[0]    <= ATT_ONE;
			att_q[1]    <= 32'sd0;
			att_q[2]    <= 32'sd0;
			att_q[3]    <= 32'sd0;
		end else begin
			// a taken result clears valid unless a new one loads this cycle
			if (out_valid_q && out_ready && state_q != ST_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cnt_q   <= 6'd0;
						state_q <= q_head.upd ? ST_SQRT_M : ST_OUT;
					end
				end
				ST_SQRT_M: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) state_q <= ST_PHI;
				end
				ST_PHI: begin
					cnt_q   <= 6'd0;
					state_q <= ST_CORDIC;
				end
				ST_CORDIC: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[4:0] == CORDIC_LAST) begin
						idx_q   <= 2'd0;
						state_q <= ST_CONE_A;
					end
				end
				ST_CONE_A: state_q <= ST_CONE_B;
				ST_CONE_B: state_q <= ST_CONE_C;
				ST_CONE_C: begin
					if (idx_q == 2'd2) begin
						idx_q   <= 2'd0;
						state_q <= ST_VMUL;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_CONE_A;
					end
				end
				ST_VMUL: begin
					cnt_q   <= 6'd0;
					state_q <= ST_VDIV;
				end
				ST_VDIV: begin
					if (cnt_q == 6'd32) begin
						cnt_q <= 6'd0;
						if (idx_q == 2'd2) begin
							state_q <= ST_NSQ;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_VMUL;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_NSQ: begin
					if (cnt_q == 6'd3) begin
						cnt_q   <= 6'd0;
						state_q <= ST_SQRT_R;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_SQRT_R: begin
					if (cnt_q == 6'd32) begin
						cnt_q   <= 6'd0;
						idx_q   <= 2'd0;
						state_q <= (sq_root_nx == 32'd0) ? ST_OUT : ST_NDIV;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_NDIV: begin
					if (cnt_q == 6'd32) begin
						cnt_q <= 6'd0;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) state_q <= ST_QMUL;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_QMUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd16) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					for (int i = 0; i < 4; i++) att_q[i] <= attn_q[i];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (busy_ld) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_head;

		// shared square root
		if (sqrt_st) begin
			if (cnt_q == 6'd0) begin
				sq_src_q  <= sq_load;
				sq_rem_q  <= 34'd0;
				sq_root_q <= 32'd0;
			end else begin
				sq_src_q  <= {sq_src_q[61:0], 2'b00};
				sq_rem_q  <= sq_ge ? 34'(sq_rem2 - sq_trial) : sq_rem2[33:0];
				sq_root_q <= sq_root_nx;
			end
		end
		if (state_q == ST_SQRT_M && cnt_q == 6'd32) m_q <= 25'(sq_root_nx);
		if (state_q == ST_SQRT_R && cnt_q == 6'd32) r_q <= sq_root_nx;

		// shared divider
		if (div_st) begin
			if (cnt_q == 6'd0) begin
				dv_rem_q <= dv_n[63:32];
				dv_lo_q  <= dv_n[31:0];
				dv_quo_q <= 32'd0;
				dv_den_q <= dv_den;
				dv_neg_q <= dv_neg;
			end else begin
				dv_rem_q <= dv_ge ? 32'(dv_rem2 - {1'b0, dv_den_q}) : dv_rem2[31:0];
				dv_lo_q  <= {dv_lo_q[30:0], 1'b0};
				dv_quo_q <= dv_quo_nx;
			end
		end

		// half angle into CORDIC
		if (state_q == ST_PHI) begin
			cx_q <= CORDIC_GAIN;
			cy_q <= 33'sd0;
			cz_q <= $signed({2'b00, phi_full[41:11]});
		end

		// CORDIC rotation
		if (state_q == ST_CORDIC) begin
			if (!cz_q[32]) begin
				cx_q <= cx_q - dxs;
				cy_q <= cy_q + dys;
				cz_q <= cz_q - atan_s;
			end else begin
				cx_q <= cx_q + dxs;
				cy_q <= cy_q - dys;
				cz_q <= cz_q + atan_s;
			end
		end

		// coning term c*dt^2/(24*2^32), rounded
		if (state_q == ST_CONE_A) cm_q <= 48'(cmag[31:0]) * 48'(time_step);
		if (state_q == ST_CONE_B) ct_q <= 64'(cm_q) * 64'(time_step) + CONE_HALF;
		if (state_q == ST_CONE_C)
			cone_q[idx_q] <= job_q.c[idx_q][32] ? -$signed({5'd0, cone_q3})
				: $signed({5'd0, cone_q3});

		// vector part
		if (state_q == ST_VMUL) begin
			vp_q   <= 50'($signed(job_q.s[idx_q]) * cy_q);
			b_q[0] <= cx_q;
		end
		if (state_q == ST_VDIV && cnt_q == 6'd32) begin
			b_q[3'(idx_q) + 3'd1 > 3'd3 ? 2'd3 : idx_q + 2'd1] <= dv_qs + cone_q[idx_q];
			nn_q <= 64'd0;
		end

		// norm squared
		if (state_q == ST_NSQ) nn_q <= nn_q + 64'(nsq_mag) * 64'(nsq_mag);

		// normalized parts
		if (state_q == ST_NDIV && cnt_q == 6'd32) b_q[idx_q] <= dv_qs;

		// quaternion product: multiply one cycle, accumulate the next
		if (state_q == ST_QMUL) begin
			if (cnt_q != 6'd16) begin
				qp_q   <= att_q[cnt_q[1:0]] * b_q[cnt_q[3:2] ^ cnt_q[1:0]];
				qneg_q <= term_neg(cnt_q[3:2], cnt_q[1:0]);
			end
			if (cnt_q != 6'd0) begin
				acc_q <= acc_nx;
				if (qu[1:0] == 2'd3) attn_q[qu[3:2]] <= fin;
			end
		end

		// result register
		if (state_q == ST_OUT && busy_ld) begin
			out_q.att_w <= to_q14(att_q[0]);
			out_q.att_x <= to_q14(att_q[1]);
			out_q.att_y <= to_q14(att_q[2]);
			out_q.att_z <= to_q14(att_q[3]);
		end
	end

endmodule

FILE: rtl/gyro_quaternion_integrator.sv
// Channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_data   (gqi_in_t: rate_x, rate_y, rate_z)
// out     | out | out_valid/out_ready | out_data  (gqi_out_t: att_w, att_x, att_y, att_z)
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (time_step, rate_threshold)
//
// A sample below threshold passes the front stages and the queue and leaves the back end
// without a rotation; an updating sample's back-end time is set by the one-bit-per-cycle square
// root (used twice) and divider (used seven times), each shared across its uses.
// Reset is asynchronous: attitude returns to identity, previous sample to zero.
// A two-entry queue lets the front keep taking samples while the back is busy;
// a held result stalls the back end, and the front once the queue is full.
module gyro_quaternion_integrator import gqi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  gqi_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output gqi_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] time_step_q;
	logic [14:0] rate_threshold_q;
	logic        q_push, q_pop, q_full, q_empty;
	gqi_job_t    q_wr, q_rd;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q      <= TIME_STEP_RST;
			rate_threshold_q <= RATE_THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TIME_STEP:      time_step_q      <= cfg_data;
				CFG_RATE_THRESHOLD: rate_threshold_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	gqi_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.rate_threshold (rate_threshold_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_entry        (q_wr)
	);

	gqi_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	gqi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_rd),
		.q_pop     (q_pop),
		.time_step (time_step_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!q_full))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!q_empty))
		else $error("queue pop while empty");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.att_w <= 16'sd16384 && out_data.att_w >= -16'sd16384 &&
			out_data.att_z <= 16'sd16384 && out_data.att_z >= -16'sd16384))
		else $error("attitude output out of range");
`endif

endmodule

FILE: bench/gyro_quaternion_integrator_tb.sv
// Self-checking bench for gyro_quaternion_integrator: a bit-exact attitude predictor
// with a scoreboard, plus random handshake pressure on the sample and result ports.
// Depends on rtl/gqi_pkg.sv and rtl/gyro_quaternion_integrator.sv.
module gyro_quaternion_integrator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gqi_pkg::*;

	localparam int STALL_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 500;

	// Predicts the attitude for each accepted sample and matches results in order
	class attitude_scoreboard;
		logic [15:0] step;
		logic [14:0] thr;
		longint att[4];
		longint prev[3];
		gqi_out_t pending[$];
		int errors;
		int updates;
		int checked;

		function new();
			step = TIME_STEP_RST;
			thr = RATE_THR_RST;
			att[0] = longint'(1) << 30;
			att[1] = 0;
			att[2] = 0;
			att[3] = 0;
			prev[0] = 0;
			prev[1] = 0;
			prev[2] = 0;
			errors = 0;
			updates = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			if (idx == CFG_TIME_STEP)
				step = val;
			else if (idx == CFG_RATE_THRESHOLD)
				thr = val[14:0];
		endfunction

		static function longint unsigned mag(longint v);
			return v < 0 ? longint'(0) - v : v;
		endfunction

		static function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, bit_w;
			r = 0;
			bit_w = 64'd1 << 62;
			while (bit_w > v)
				bit_w >>= 2;
			while (bit_w != 0) begin
				if (v >= r + bit_w) begin
					v -= r + bit_w;
					r = (r >> 1) + bit_w;
				end else begin
					r >>= 1;
				end
				bit_w >>= 2;
			end
			return r;
		endfunction

		// Half away from zero
		static function longint div_round(longint num, longint unsigned den);
			longint unsigned q;
			q = (mag(num) + den / 2) / den;
			return num < 0 ? -longint'(q) : longint'(q);
		endfunction

		static function longint prod(longint a, longint b);
			return (a * b) >>> 2;
		endfunction

		static function longint settle(longint acc);
			longint v;
			v = (acc + (longint'(1) << 27)) >>> 28;
			if (v > 64'sd2147483647)
				v = 64'sd2147483647;
			if (v < -64'sd2147483648)
				v = -64'sd2147483648;
			return v;
		endfunction

		// Attitude update for one sample; skipped below threshold or at zero norm
		function void rotate(longint nr[3]);
			longint s[3], c[3], b[4], a[4], x, y, z, dx, dy;
			longint unsigned n2, m, phi, r, nn, t64, den, q;
			n2 = 0;
			nn = 0;
			for (int i = 0; i < 3; i++) begin
				s[i] = nr[i] + prev[i];
				n2 += mag(s[i]) * mag(s[i]);
			end
			t64 = thr;
			if (!(n2 > 4 * t64 * t64))
				return;
			m = int_sqrt(n2 << 16);
			phi = (m * longint'(step) + 1024) >> 11;
			x = CORDIC_GAIN;
			y = 0;
			z = phi;
			for (int i = 0; i < 30; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= longint'(atan_entry(i[4:0]));
				end else begin
					x += dx;
					y -= dy;
					z += longint'(atan_entry(i[4:0]));
				end
			end
			// coning: previous x new
			c[0] = prev[1] * nr[2] - prev[2] * nr[1];
			c[1] = prev[2] * nr[0] - prev[0] * nr[2];
			c[2] = prev[0] * nr[1] - prev[1] * nr[0];
			den = 64'd24 << 32;
			b[0] = x;
			for (int i = 0; i < 3; i++) begin
				q = (mag(c[i]) * longint'(step) * longint'(step) + den / 2) / den;
				b[i + 1] = div_round(s[i] * y * 256, m) + (c[i] < 0 ? -longint'(q) : longint'(q));
			end
			for (int i = 0; i < 4; i++)
				nn += mag(b[i]) * mag(b[i]);
			r = int_sqrt(nn);
			if (r == 0)
				return;
			for (int i = 0; i < 4; i++) begin
				b[i] = div_round(b[i] * (longint'(1) << 30), r);
				a[i] = att[i];
			end
			att[0] = settle(prod(a[0], b[0]) - prod(a[1], b[1]) - prod(a[2], b[2])
				- prod(a[3], b[3]));
			att[1] = settle(prod(a[0], b[1]) + prod(a[1], b[0]) + prod(a[2], b[3])
				- prod(a[3], b[2]));
			att[2] = settle(prod(a[0], b[2]) - prod(a[1], b[3]) + prod(a[2], b[0])
				+ prod(a[3], b[1]));
			att[3] = settle(prod(a[0], b[3]) + prod(a[1], b[2]) - prod(a[2], b[1])
				+ prod(a[3], b[0]));
			updates++;
		endfunction

		// Accepted sample: advance the model and queue the expected attitude
		function void note_sample(gqi_in_t d);
			longint nr[3], v;
			logic signed [15:0] o[4];
			nr[0] = d.rate_x;
			nr[1] = d.rate_y;
			nr[2] = d.rate_z;
			rotate(nr);
			for (int i = 0; i < 3; i++)
				prev[i] = nr[i];
			for (int i = 0; i < 4; i++) begin
				v = (att[i] + 32768) >>> 16;
				if (v > 16384)
					v = 16384;
				if (v < -16384)
					v = -16384;
				o[i] = v[15:0];
			end
			pending.push_back('{att_w: o[0], att_x: o[1], att_y: o[2], att_z: o[3]});
		endfunction

		function void check_result(gqi_out_t act);
			gqi_out_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", act);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (act.att_w !== e.att_w) begin
				$error("att_w: expected %0d, got %0d", e.att_w, act.att_w);
				errors++;
			end
			if (act.att_x !== e.att_x) begin
				$error("att_x: expected %0d, got %0d", e.att_x, act.att_x);
				errors++;
			end
			if (act.att_y !== e.att_y) begin
				$error("att_y: expected %0d, got %0d", e.att_y, act.att_y);
				errors++;
			end
			if (act.att_z !== e.att_z) begin
				$error("att_z: expected %0d, got %0d", e.att_z, act.att_z);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	gqi_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	gqi_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	attitude_scoreboard sb = new();
	bit calm = 1'b0;
	int idle_cycles = 0;

	gyro_quaternion_integrator DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: random stall bursts, check at the rising edge
	always @(negedge clk) begin
		if (!calm && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		out_ready <= 1'b1;
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("handshake timeout after %0d idle cycles", STALL_LIMIT);
			$display("gyro_quaternion_integrator regression: fail");
			$finish;
		end
	end

	task automatic send_sample(gqi_in_t d);
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(d);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Let every expected attitude come back, then give the back end time to settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_rate(int kind);
		unique case (kind)
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($signed($urandom_range(0, 8000)) - 4000);
			2: return 16'($signed($urandom_range(0, 200)) - 100);
			default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	task automatic random_run(int n);
		gqi_in_t d;
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			kind = (kind < 3) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
			if ($urandom_range(0, 19) == 0)
				d = '0;
			else
				d = '{pick_rate(kind), pick_rate(kind), pick_rate(kind)};
			send_sample(d);
		end
	endtask

	initial begin
		gqi_in_t dir_set[$];
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: zero rate, axis extremes, sign flips for coning, tiny rates
		dir_set = '{'0, '{16'sh7fff, 0, 0}, '{0, 16'sh7fff, 0}, '{0, 0, 16'sh7fff},
			'{16'sh8000, 0, 0}, '{0, 16'sh8000, 0}, '{0, 0, 16'sh8000},
			'{16'sh7fff, 16'sh7fff, 16'sh7fff}, '{16'sh8000, 16'sh8000, 16'sh8000},
			'{16'sh7fff, 16'sh8000, 16'sh7fff}, '{16'sh8000, 16'sh7fff, 16'sh8000},
			'{1, 0, 0}, '{-1, 0, 0}, '{0, 1, -1}, '{2000, -1500, 700},
			'{-1500, 700, 2000}, '{700, 2000, -1500}, '0, '0};
		foreach (dir_set[i])
			send_sample(dir_set[i]);
		drain();

		// Thresholds at the extremes, then both unused register indexes
		write_reg(CFG_RATE_THRESHOLD, 16'h7fff);
		foreach (dir_set[i])
			send_sample(dir_set[i]);
		drain();
		write_reg(2'd2, 16'hffff);
		write_reg(2'd3, 16'h0000);
		write_reg(CFG_RATE_THRESHOLD, 16'd300);
		random_run(250);
		drain();

		write_reg(CFG_TIME_STEP, 16'hffff);
		write_reg(CFG_RATE_THRESHOLD, 16'd0);
		random_run(250);
		drain();

		write_reg(CFG_TIME_STEP, 16'd0);
		random_run(150);
		drain();

		write_reg(CFG_TIME_STEP, 16'd1);
		write_reg(CFG_RATE_THRESHOLD, 16'($urandom_range(0, 2000)));
		random_run(200);
		drain();

		write_reg(CFG_TIME_STEP, 16'($urandom_range(0, 65535)));
		write_reg(CFG_RATE_THRESHOLD, 16'($urandom_range(0, 32767)));
		random_run(200);
		drain();

		// Closing stretch at full rate on both sides
		write_reg(CFG_TIME_STEP, 16'd10486);
		write_reg(CFG_RATE_THRESHOLD, 16'd50);
		calm = 1'b1;
		random_run(350);
		drain();

		$display("checked %0d attitude results, %0d of them rotated, over several",
			sb.checked, sb.updates);
		$display("time step and threshold settings with random stalls on both sides");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("gyro_quaternion_integrator regression: pass");
		else
			$display("gyro_quaternion_integrator regression: fail");
		$finish;
	end
endmodule

FILE: files.f
rtl/gqi_pkg.sv
rtl/gqi_front.sv
rtl/gqi_queue.sv
rtl/gqi_back.sv
rtl/gyro_quaternion_integrator.sv
bench/gyro_quaternion_integrator_tb.sv
